@@ sv/jcd_pkg.sv @@
// Package for the Jukes-Cantor distance block: constants, types, case fold.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps

package jcd_pkg;

  // sequence length limit and output format
  localparam int MAX_LEN   = 1048576;
  localparam int FRAC_BITS = 16;
  localparam int DIST_W    = 20;

  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int SCORE_W = $clog2(4 * MAX_LEN + 1);
  localparam int THREE_W = $clog2(3 * MAX_LEN + 1);

  // log2 datapath
  localparam int LOG_FRAC = 30;
  localparam int M_W      = LOG_FRAC + 1;
  localparam int E_W      = $clog2(THREE_W);
  localparam int LOG_W    = E_W + LOG_FRAC;
  localparam int STEP_W   = $clog2(LOG_FRAC);
  localparam int NORM_SH  = LOG_FRAC - (THREE_W - 1);

  // 0.75*ln2 in Q0.28, split multiply of the log difference
  localparam int C_FRAC     = 28;
  localparam logic [31:0] C_SCALED = 32'd139548960;
  localparam int MUL_SPLIT  = 18;
  localparam int RND_SH     = LOG_FRAC + C_FRAC - FRAC_BITS;

  localparam longint DIST_MAX_L = (longint'(1) << DIST_W) - 1;
  localparam longint CAP_RAW    = longint'(10) << FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(DIST_MAX_L);
  localparam logic [DIST_W-1:0] DIST_CAP =
    DIST_W'((CAP_RAW > DIST_MAX_L) ? DIST_MAX_L : CAP_RAW);

  localparam logic [7:0] CHAR_N  = 8'h4E;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_HOLD
  } top_state_e;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_NORM,
    DS_SQR,
    DS_MUL_LO,
    DS_MUL_HI,
    DS_ROUND
  } dist_state_e;

  typedef struct packed {
    logic               start;
    logic [THREE_W-1:0] three_len;
    logic [THREE_W-1:0] remain;
  } dist_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] distance;
  } dist_rsp_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LA && c <= CHAR_LZ) begin
      r = c - CASE_OFS;
    end
    return r;
  endfunction

endpackage

@@ sv/jcd_if.sv @@
// Valid/ready channel interfaces for base-pair beats and distance beats.
// Depends on jcd_pkg.
`timescale 1ns / 1ps

interface jcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_a;
  logic [7:0] base_b;
  logic       last_pair;

  modport source (output valid, output base_a, output base_b, output last_pair,
                  input ready);
  modport sink (input valid, input base_a, input base_b, input last_pair,
                output ready);
endinterface

interface jcd_out_if;
  logic                      valid;
  logic                      ready;
  logic [jcd_pkg::DIST_W-1:0] distance;
  logic                      capped;
  logic                      length_overflow;

  modport source (output valid, output distance, output capped,
                  output length_overflow, input ready);
  modport sink (input valid, input distance, input capped,
                input length_overflow, output ready);
endinterface

@@ sv/jcd_dist_unit.sv @@
// Iterative distance unit: log2 by normalize + repeated squaring on one
// shared 32x32 multiplier, then scale by 0.75*ln2. Depends on jcd_pkg.
`timescale 1ns / 1ps

module jcd_dist_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jcd_pkg::dist_req_t req_i,
  output jcd_pkg::dist_rsp_t rsp_o
);

  jcd_pkg::dist_state_e state_q, state_d;

  logic [jcd_pkg::M_W-1:0]      m_q, m_d;
  logic [jcd_pkg::E_W-1:0]      e_q, e_d;
  logic [jcd_pkg::LOG_FRAC-1:0] frac_q, frac_d;
  logic [jcd_pkg::STEP_W-1:0]   step_q, step_d;
  logic                         pass_q, pass_d;
  logic [jcd_pkg::THREE_W-1:0]  b_q, b_d;
  logic [jcd_pkg::LOG_W-1:0]    la_q, la_d;
  logic [jcd_pkg::LOG_W-1:0]    d_q, d_d;
  logic [63:0]                  acc_q, acc_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] sq;
  logic [jcd_pkg::LOG_W-1:0] log_r;
  logic [63:0] rnd_sum, rnd_val;
  logic [jcd_pkg::DIST_W-1:0] dist_sat;

  // the one shared multiplier
  assign prod = mul_a * mul_b;
  assign sq   = prod[2*jcd_pkg::LOG_FRAC+1:jcd_pkg::LOG_FRAC];

  assign rnd_sum  = acc_q + (64'd1 << (jcd_pkg::RND_SH - 1));
  assign rnd_val  = rnd_sum >> jcd_pkg::RND_SH;
  assign dist_sat = (rnd_val > 64'(jcd_pkg::DIST_MAX)) ? jcd_pkg::DIST_MAX
                                                       : rnd_val[jcd_pkg::DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jcd_pkg::DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    e_q    <= e_d;
    frac_q <= frac_d;
    step_q <= step_d;
    pass_q <= pass_d;
    b_q    <= b_d;
    la_q   <= la_d;
    d_q    <= d_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    e_d     = e_q;
    frac_d  = frac_q;
    step_d  = step_q;
    pass_d  = pass_q;
    b_d     = b_q;
    la_d    = la_q;
    d_d     = d_q;
    acc_d   = acc_q;
    mul_a   = '0;
    mul_b   = '0;
    log_r   = {e_q, frac_q};
    rsp_o   = '0;

    unique case (state_q)
      jcd_pkg::DS_IDLE: begin
        if (req_i.start) begin
          m_d     = jcd_pkg::M_W'(req_i.three_len) << jcd_pkg::NORM_SH;
          e_d     = jcd_pkg::E_W'(jcd_pkg::THREE_W - 1);
          b_d     = req_i.remain;
          pass_d  = 1'b0;
          state_d = jcd_pkg::DS_NORM;
        end
      end
      jcd_pkg::DS_NORM: begin
        // one leading-zero shift per cycle until the integer bit is set
        if (m_q[jcd_pkg::M_W-1]) begin
          step_d  = jcd_pkg::STEP_W'(jcd_pkg::LOG_FRAC - 1);
          frac_d  = '0;
          state_d = jcd_pkg::DS_SQR;
        end else begin
          m_d = m_q << 1;
          e_d = e_q - 1'b1;
        end
      end
      jcd_pkg::DS_SQR: begin
        mul_a = 32'(m_q);
        mul_b = 32'(m_q);
        if (sq[jcd_pkg::M_W]) begin
          m_d            = sq[jcd_pkg::M_W:1];
          frac_d[step_q] = 1'b1;
        end else begin
          m_d = sq[jcd_pkg::M_W-1:0];
        end
        log_r = {e_q, frac_d};
        if (step_q == '0) begin
          if (!pass_q) begin
            la_d    = log_r;
            m_d     = jcd_pkg::M_W'(b_q) << jcd_pkg::NORM_SH;
            e_d     = jcd_pkg::E_W'(jcd_pkg::THREE_W - 1);
            pass_d  = 1'b1;
            state_d = jcd_pkg::DS_NORM;
          end else begin
            d_d     = (la_q > log_r) ? la_q - log_r : '0;
            state_d = jcd_pkg::DS_MUL_LO;
          end
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      jcd_pkg::DS_MUL_LO: begin
        mul_a   = 32'(d_q[jcd_pkg::MUL_SPLIT-1:0]);
        mul_b   = jcd_pkg::C_SCALED;
        acc_d   = prod;
        state_d = jcd_pkg::DS_MUL_HI;
      end
      jcd_pkg::DS_MUL_HI: begin
        mul_a   = 32'(d_q[jcd_pkg::LOG_W-1:jcd_pkg::MUL_SPLIT]);
        mul_b   = jcd_pkg::C_SCALED;
        acc_d   = acc_q + (prod << jcd_pkg::MUL_SPLIT);
        state_d = jcd_pkg::DS_ROUND;
      end
      jcd_pkg::DS_ROUND: begin
        rsp_o.done     = 1'b1;
        rsp_o.distance = dist_sat;
        state_d        = jcd_pkg::DS_IDLE;
      end
      default: begin
        state_d = jcd_pkg::DS_IDLE;
      end
    endcase
  end

endmodule

@@ sv/jukes_cantor_distance.sv @@
// Jukes-Cantor distance: one aligned base pair per beat, taken while idle.
// A beat with last_pair set starts the distance unit unless the result is
// capped; the block is busy while the unit takes two logs (normalize, then
// one squaring per cycle on the shared multiplier), multiplies and rounds.
// A capped last beat skips the unit; output back-pressure adds.
// Reset (async, active low) clears counters, sequencer and output valid.
`timescale 1ns / 1ps

module jukes_cantor_distance (
  input  logic      clk_i,
  input  logic      rst_ni,
  jcd_in_if.sink    in_i,
  jcd_out_if.source out_o
);

  jcd_pkg::top_state_e state_q, state_d;

  // running column statistics
  logic [jcd_pkg::CNT_W-1:0]   cnt_q, cnt_nx;
  logic [jcd_pkg::SCORE_W-1:0] score_q, score_nx;
  logic                        ovf_q, ovf_nx;

  // pending result, then output register
  logic [jcd_pkg::DIST_W-1:0] res_dist_q;
  logic                       res_cap_q;
  logic                       res_ovf_q;
  logic                       out_valid_q;
  logic [jcd_pkg::DIST_W-1:0] out_dist_q;
  logic                       out_cap_q;
  logic                       out_ovf_q;

  logic [7:0] a_f, b_f;
  logic       at_max, is_n;
  logic [2:0] add_q4;
  logic [jcd_pkg::THREE_W-1:0] three_len, remain;
  logic       capped_nx;
  logic       in_fire, out_load;

  jcd_pkg::dist_req_t req;
  jcd_pkg::dist_rsp_t rsp;

  assign in_i.ready = (state_q == jcd_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // fold case, classify the column
  assign a_f    = jcd_pkg::fold_case(in_i.base_a);
  assign b_f    = jcd_pkg::fold_case(in_i.base_b);
  assign is_n   = (a_f == jcd_pkg::CHAR_N) || (b_f == jcd_pkg::CHAR_N);
  assign add_q4 = is_n ? 3'd3 : ((a_f != b_f) ? 3'd4 : 3'd0);
  assign at_max = (cnt_q == jcd_pkg::CNT_W'(jcd_pkg::MAX_LEN));

  // a column at the length limit is dropped and only flagged
  assign cnt_nx   = at_max ? cnt_q : cnt_q + 1'b1;
  assign score_nx = at_max ? score_q : score_q + jcd_pkg::SCORE_W'(add_q4);
  assign ovf_nx   = ovf_q | at_max;

  // 3*len as shift-add; capped when score reaches it
  assign three_len = (jcd_pkg::THREE_W'(cnt_nx) << 1) + jcd_pkg::THREE_W'(cnt_nx);
  assign capped_nx = (jcd_pkg::SCORE_W'(three_len) <= score_nx);
  assign remain    = three_len - jcd_pkg::THREE_W'(score_nx);

  assign out_load = (state_q == jcd_pkg::ST_HOLD) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d       = state_q;
    req.start     = 1'b0;
    req.three_len = three_len;
    req.remain    = remain;
    unique case (state_q)
      jcd_pkg::ST_IDLE: begin
        if (in_fire && in_i.last_pair) begin
          if (capped_nx) begin
            state_d = jcd_pkg::ST_HOLD;
          end else begin
            req.start = 1'b1;
            state_d   = jcd_pkg::ST_CALC;
          end
        end
      end
      jcd_pkg::ST_CALC: begin
        if (rsp.done) begin
          state_d = jcd_pkg::ST_HOLD;
        end
      end
      jcd_pkg::ST_HOLD: begin
        if (out_load) begin
          state_d = jcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jcd_pkg::ST_IDLE;
      cnt_q       <= '0;
      score_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (in_i.last_pair) begin
          cnt_q   <= '0;
          score_q <= '0;
          ovf_q   <= 1'b0;
        end else begin
          cnt_q   <= cnt_nx;
          score_q <= score_nx;
          ovf_q   <= ovf_nx;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.last_pair) begin
      res_ovf_q  <= ovf_nx;
      res_cap_q  <= capped_nx;
      res_dist_q <= jcd_pkg::DIST_CAP;
    end else if (state_q == jcd_pkg::ST_CALC && rsp.done) begin
      res_dist_q <= rsp.distance;
    end
    if (out_load) begin
      out_dist_q <= res_dist_q;
      out_cap_q  <= res_cap_q;
      out_ovf_q  <= res_ovf_q;
    end
  end

  jcd_dist_unit u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.distance        = out_dist_q;
  assign out_o.capped          = out_cap_q;
  assign out_o.length_overflow = out_ovf_q;

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= jcd_pkg::CNT_W'(jcd_pkg::MAX_LEN))
    else $error("pair count above limit");

  a_score_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (25'(score_q) <= (25'(cnt_q) << 2)))
    else $error("score exceeds four quarters per pair");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_pair) |=> (cnt_q == '0 && score_q == '0 && !ovf_q))
    else $error("counters not cleared after last pair");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == jcd_pkg::ST_CALC))
    else $error("distance unit done outside calc");

  a_cap_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cap_q) |-> (out_dist_q == jcd_pkg::DIST_CAP))
    else $error("capped result with wrong distance");

endmodule
